[design/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the range mode query block.
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;
  localparam int unsigned DEF_ARRAY_DEPTH = 1024;
  localparam int unsigned DEF_VALUE_RANGE = 1024;
  localparam int unsigned FIELD_W         = 10;
  localparam int unsigned COUNT_OUT_W     = 11;
  localparam logic        OP_LOAD         = 1'b0;
  localparam logic        OP_QUERY        = 1'b1;
endpackage
`default_nettype wire

[design/range_mode_query_top.sv]
// ----------------------------------------------------------------------------
// range_mode_query_top
// A load writes the array and, when it follows a query, then clears all
// VALUE_RANGE entries of the count RAM. A query sets up its segments, reads the
// array and then reads and writes the count RAM for each index the window moves,
// then scans the count RAM for its maximum; a reversed range answers without a
// scan. One item at a time; the count RAM access per step sets the rate. Reset:
// synchronous, then a clearing pass over the count RAM with stall high.
// ----------------------------------------------------------------------------
`default_nettype none
module range_mode_query_top #(
  parameter int unsigned ARRAY_DEPTH = rmq_pkg::DEF_ARRAY_DEPTH,
  parameter int unsigned VALUE_RANGE = rmq_pkg::DEF_VALUE_RANGE
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic                            op,
  input  wire logic [rmq_pkg::FIELD_W-1:0]     position,
  input  wire logic [rmq_pkg::FIELD_W-1:0]     entry_value,
  input  wire logic [rmq_pkg::FIELD_W-1:0]     range_low,
  input  wire logic [rmq_pkg::FIELD_W-1:0]     range_high,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic [rmq_pkg::FIELD_W-1:0]          mode_value,
  output logic [rmq_pkg::COUNT_OUT_W-1:0]      mode_count,
  output logic                                 bad_range
);
  localparam int unsigned AW = $clog2(ARRAY_DEPTH);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned VW = $clog2(VALUE_RANGE);
  localparam int unsigned CW = $clog2(ARRAY_DEPTH + 1);
  localparam int unsigned MW = 30;
  localparam int unsigned RS = 20;
  localparam logic [MW-1:0] RECIP = MW'((1 << RS) / VALUE_RANGE);
  localparam logic [IW-1:0] LAST_IDX = IW'(ARRAY_DEPTH - 1);
  localparam logic [VW-1:0] LAST_VAL = VW'(VALUE_RANGE - 1);
  localparam logic [CW-1:0] COUNT_SAT = CW'(2047);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_LWR, S_CLR, S_SEG, S_ARD, S_CRD, S_CWR,
    S_SCAN, S_SLAST, S_OUT
  } state_t;

  state_t                      state;
  logic [rmq_pkg::FIELD_W-1:0] rem;
  logic [rmq_pkg::FIELD_W-1:0] quo;
  logic [1:0]                  mod_k;
  logic [rmq_pkg::FIELD_W-1:0] ld_pos;
  logic                        window_empty;
  logic [IW-1:0]               ws, we, lo, hi, cur, last;
  logic [1:0]                  seg;
  logic                        dec;
  logic [VW-1:0]               vidx;
  logic [VW-1:0]               sv_addr;
  logic                        sv_valid;
  logic [VW-1:0]               best_v;
  logic [CW-1:0]               best_c;
  logic                        res_bad;

  logic                        arr_we;
  logic [AW-1:0]               arr_raddr;
  logic [VW-1:0]               arr_rdata;
  logic                        cnt_we;
  logic [VW-1:0]               cnt_waddr, cnt_raddr;
  logic [CW-1:0]               cnt_wdata, cnt_rdata;
  logic [MW-1:0]               mod_prod;
  logic [MW-1:0]               mod_sub;
  logic [IW-1:0]               lo_sat, hi_sat;

  rmq_ram #(.WIDTH(VW), .DEPTH(ARRAY_DEPTH)) u_arr (
    .clk(clk), .we(arr_we), .waddr(ld_pos[AW-1:0]), .wdata(rem[VW-1:0]),
    .raddr(arr_raddr), .rdata(arr_rdata)
  );

  rmq_ram #(.WIDTH(CW), .DEPTH(VALUE_RANGE)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  always_comb begin
    mod_prod  = MW'(rem) * RECIP;
    mod_sub   = MW'(quo) * MW'(VALUE_RANGE);
    lo_sat    = (32'(range_low) > ARRAY_DEPTH - 1) ? LAST_IDX : IW'(range_low);
    hi_sat    = (32'(range_high) > ARRAY_DEPTH - 1) ? LAST_IDX : IW'(range_high);
    req_stall = (state != S_IDLE);
    arr_we    = (state == S_LWR) && (32'(ld_pos) < ARRAY_DEPTH);
    arr_raddr = cur[AW-1:0];
    cnt_raddr = (state == S_CRD) ? arr_rdata : vidx;
    cnt_waddr = (state == S_CLR) ? vidx : sv_addr;
    cnt_we    = (state == S_CLR) || (state == S_CWR);
    cnt_wdata = '0;
    if (state == S_CWR) begin
      if (!dec) begin
        cnt_wdata = cnt_rdata + CW'(1);
      end else if (cnt_rdata != '0) begin
        cnt_wdata = cnt_rdata - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      vidx         <= '0;
      window_empty <= 1'b1;
      ws           <= '0;
      we           <= '0;
      sv_valid     <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (op == rmq_pkg::OP_LOAD) begin
              rem    <= entry_value;
              ld_pos <= position;
              mod_k  <= 2'd0;
              state  <= S_MOD;
            end else if (range_low > range_high) begin
              res_bad <= 1'b1;
              state   <= S_OUT;
            end else begin
              lo    <= lo_sat;
              hi    <= hi_sat;
              seg   <= '0;
              state <= S_SEG;
            end
          end
        end
        S_MOD: begin
          mod_k <= mod_k + 2'd1;
          if (mod_k == 2'd0) begin
            quo <= mod_prod[RS +: rmq_pkg::FIELD_W];
          end else if (mod_k == 2'd1) begin
            rem <= rem - rmq_pkg::FIELD_W'(mod_sub);
          end else begin
            if (MW'(rem) >= MW'(VALUE_RANGE)) begin
              rem <= rem - rmq_pkg::FIELD_W'(VALUE_RANGE);
            end
            state <= S_LWR;
          end
        end
        S_LWR: begin
          window_empty <= 1'b1;
          ws           <= '0;
          we           <= '0;
          vidx         <= '0;
          state        <= window_empty ? S_IDLE : S_CLR;
        end
        S_CLR: begin
          vidx <= vidx + VW'(1);
          if (vidx == LAST_VAL) begin
            vidx  <= '0;
            state <= S_IDLE;
          end
        end
        S_SEG: begin
          seg   <= seg + 2'd1;
          state <= S_SEG;
          unique case (seg)
            2'd0: begin
              dec <= 1'b0;
              cur <= lo;
              if (window_empty) begin
                last  <= hi;
                seg   <= 2'd3;
                state <= S_ARD;
              end else if (lo < ws) begin
                last  <= ws - IW'(1);
                state <= S_ARD;
              end
            end
            2'd1: begin
              dec  <= 1'b0;
              cur  <= we + IW'(1);
              last <= hi;
              if (hi > we) begin
                state <= S_ARD;
              end
            end
            2'd2: begin
              dec  <= 1'b1;
              cur  <= ws;
              last <= lo - IW'(1);
              if (ws < lo) begin
                state <= S_ARD;
              end
            end
            default: begin
              dec  <= 1'b1;
              cur  <= hi + IW'(1);
              last <= we;
              if (we > hi) begin
                state <= S_ARD;
              end else begin
                vidx     <= '0;
                best_v   <= '0;
                best_c   <= '0;
                sv_valid <= 1'b0;
                state    <= S_SCAN;
              end
            end
          endcase
          if (seg == 2'd3 && !(window_empty && seg == 2'd0)) begin
            ws           <= lo;
            we           <= hi;
            window_empty <= 1'b0;
          end
        end
        S_ARD: begin
          state <= S_CRD;
        end
        S_CRD: begin
          sv_addr <= arr_rdata;
          state   <= S_CWR;
        end
        S_CWR: begin
          if (cur == last) begin
            if (seg == 2'd0) begin
              ws           <= lo;
              we           <= hi;
              window_empty <= 1'b0;
              vidx         <= '0;
              best_v       <= '0;
              best_c       <= '0;
              sv_valid     <= 1'b0;
              state        <= S_SCAN;
            end else begin
              state <= S_SEG;
            end
          end else begin
            cur   <= cur + IW'(1);
            state <= S_ARD;
          end
        end
        S_SCAN, S_SLAST: begin
          if (sv_valid && cnt_rdata > best_c) begin
            best_c <= cnt_rdata;
            best_v <= sv_addr;
          end
          sv_valid <= (state == S_SCAN);
          sv_addr  <= vidx;
          vidx     <= vidx + VW'(1);
          if (state == S_SLAST) begin
            res_bad <= 1'b0;
            state   <= S_OUT;
          end else if (vidx == LAST_VAL) begin
            state <= S_SLAST;
          end
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid  <= 1'b1;
            mode_value <= res_bad ? '0 : rmq_pkg::FIELD_W'(best_v);
            mode_count <= res_bad ? '0 :
                          (best_c > COUNT_SAT) ? rmq_pkg::COUNT_OUT_W'(2047)
                                               : rmq_pkg::COUNT_OUT_W'(best_c);
            bad_range  <= res_bad;
            vidx       <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/rmq_ram.sv]
// ----------------------------------------------------------------------------
// rmq_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks on the range mode query block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_stall,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic [9:0]  mode_value,
  input wire logic [10:0] mode_count,
  input wire logic        bad_range
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(mode_value) &&
    $stable(mode_count) && $stable(bad_range))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && bad_range |-> mode_value == '0 && mode_count == '0)
    else $error("reversed range with nonzero fields");

  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !bad_range |-> mode_count != '0)
    else $error("good range with zero count");

  a_rst_out: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_stall)
    else $error("reset left result or accepted input");
endmodule

bind range_mode_query_top rmq_checker u_rmq_checker (
  .clk(clk), .rst(rst), .req_stall(req_stall), .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall), .mode_value(mode_value), .mode_count(mode_count),
  .bad_range(bad_range)
);
`default_nettype wire
